FILE: src/vpma_pkg.sv
// Types and constants shared by the VGA planar memory access unit.
`default_nettype none
package vpma_pkg;

   // Request word: one CPU byte access
   typedef struct packed {
      logic        func;        // 0 read, 1 write
      logic [19:0] address;     // linear CPU byte address
      logic [7:0]  write_data;  // byte written, ignored on read
   } req_word_type;

   // Response word
   typedef struct packed {
      logic       hit;          // address fell inside the enabled window
      logic [7:0] read_data;    // byte read on a read hit, else zero
   } rsp_word_type;

   // Register file port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_SETRESET = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLOR    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROTATE   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_MASK = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_MASK = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW   = 3'd6;

   // Register reset values
   localparam logic [7:0] SETRESET_RST = 8'd0;
   localparam logic [7:0] COLOR_RST    = 8'd0;
   localparam logic [4:0] ROTATE_RST   = 5'd0;
   localparam logic [6:0] MODE_RST     = 7'd64;
   localparam logic [7:0] BIT_MASK_RST = 8'hFF;
   localparam logic [3:0] MAP_MASK_RST = 4'hF;
   localparam logic [4:0] WINDOW_RST   = 5'd1;

   // Memory map window bounds
   localparam logic [19:0] WIN_A0000 = 20'hA0000;
   localparam logic [19:0] WIN_B0000 = 20'hB0000;
   localparam logic [19:0] WIN_B8000 = 20'hB8000;
   localparam logic [19:0] WIN_C0000 = 20'hC0000;

   // Memory map select
   localparam logic [1:0] MAP_A0000_128K = 2'd0;
   localparam logic [1:0] MAP_A0000_64K  = 2'd1;
   localparam logic [1:0] MAP_B0000_32K  = 2'd2;
   localparam logic [1:0] MAP_B8000_32K  = 2'd3;

   // Addressing modes
   localparam logic [1:0] ADDR_PLANAR  = 2'd0;
   localparam logic [1:0] ADDR_CHAIN4  = 2'd1;
   localparam logic [1:0] ADDR_ODDEVEN = 2'd2;

   // Write modes
   localparam logic [1:0] WMODE_0 = 2'd0;
   localparam logic [1:0] WMODE_1 = 2'd1;
   localparam logic [1:0] WMODE_2 = 2'd2;
   localparam logic [1:0] WMODE_3 = 2'd3;

   // ALU logic ops against the latch
   localparam logic [1:0] LOP_NONE = 2'd0;
   localparam logic [1:0] LOP_AND  = 2'd1;
   localparam logic [1:0] LOP_OR   = 2'd2;
   localparam logic [1:0] LOP_XOR  = 2'd3;

   // Odd/even plane pair pattern (plane and the one two above)
   localparam logic [3:0] ODDEVEN_PAIR = 4'b0101;

endpackage
`default_nettype wire

FILE: src/vga_planar_memory_access_unit.sv
// VGA planar memory access unit: window decode, write modes 0-3, read modes 0-1.
//
//   channel  direction  handshake              word
//   req      in         req_valid / req_stall  req_word_type (func, address, write_data)
//   rsp      out        rsp_valid / rsp_stall  rsp_word_type (hit, read_data)
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// A write or a miss passes the result stage and the response register; a read
// hit first waits in ST_READ: the video memory returns the four planes registered
// from the address, then the latch loads and the response is formed. A response
// register and a result stage separate the sides, so one new word is taken while a response stalls.
// After reset the video memory is cleared one entry per cycle, with req_stall
// high until it is done; register writes are taken at all times out of reset.
`default_nettype none
module vga_planar_memory_access_unit #(
   parameter int PLANE_ADDR_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  vpma_pkg::req_word_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output vpma_pkg::rsp_word_type              rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [vpma_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [vpma_pkg::CSR_DATA_W-1:0]     csr_data
);
   import vpma_pkg::*;

   localparam int Depth = 2 ** PLANE_ADDR_BITS;

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ} state_type;

   // Registers
   state_type                  state_ff;
   logic [PLANE_ADDR_BITS-1:0] clr_addr_ff;
   logic [7:0]                 setreset_ff;
   logic [7:0]                 color_ff;
   logic [4:0]                 rotate_ff;
   logic [6:0]                 mode_ff;
   logic [7:0]                 bit_mask_ff;
   logic [3:0]                 map_mask_ff;
   logic [4:0]                 window_ff;
   logic [31:0]                latch_ff;
   logic [3:0]                 planes_ff;
   logic                       res_valid_ff;
   rsp_word_type               res_ff;
   logic                       rsp_valid_ff;
   rsp_word_type               rsp_ff;

   // Video memory
   logic [31:0]                vram_mem [Depth];
   logic [31:0]                mem_q_ff;

   // Combinational
   logic                       accept;
   logic [19:0]                win_start;
   logic [19:0]                win_end;
   logic                       hit;
   logic [19:0]                off_full;
   logic [16:0]                off;
   logic [16:0]                poff_wide;
   logic [PLANE_ADDR_BITS-1:0] poff;
   logic [3:0]                 planes;
   logic [1:0]                 oe_sel;
   logic [7:0]                 oe_pair;
   logic [7:0]                 rot_byte;
   logic [15:0]                rot_dbl;
   logic [31:0]                sr_data;
   logic [31:0]                lop_src;
   logic [31:0]                lop_out;
   logic [31:0]                mask_expand;
   logic [31:0]                wr_value;
   logic [7:0]                 m3_mask;
   logic                       mem_we;
   logic [PLANE_ADDR_BITS-1:0] mem_waddr;
   logic [31:0]                mem_wdata;
   logic [3:0]                 mem_be;
   logic [31:0]                latch_in;
   logic [31:0]                cmp_r;
   logic [7:0]                 rd_byte;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || res_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Window decode
   always_comb begin
      case (window_ff[2:1])
         MAP_A0000_128K: begin
            win_start = WIN_A0000;
            win_end   = WIN_C0000;
         end
         MAP_A0000_64K: begin
            win_start = WIN_A0000;
            win_end   = WIN_B0000;
         end
         MAP_B0000_32K: begin
            win_start = WIN_B0000;
            win_end   = WIN_B8000;
         end
         default: begin
            win_start = WIN_B8000;
            win_end   = WIN_C0000;
         end
      endcase
   end

   assign hit      = window_ff[0] && (req_data.address >= win_start)
                     && (req_data.address < win_end);
   assign off_full = req_data.address - win_start;
   assign off      = off_full[16:0];

   // Plane select and plane offset
   assign oe_sel  = {~window_ff[4], off[0]};
   assign oe_pair = 8'(ODDEVEN_PAIR) << oe_sel;

   always_comb begin
      case (mode_ff[6:5])
         ADDR_CHAIN4: begin
            planes    = 4'b0001 << off[1:0];
            poff_wide = {off[16:2], 2'b00};
         end
         ADDR_ODDEVEN: begin
            planes    = oe_pair[3:0];
            poff_wide = {off[16:1], (window_ff[3] ? off[16] : off[0])};
         end
         default: begin
            planes    = req_data.func ? 4'hF : (4'b0001 << mode_ff[4:3]);
            poff_wide = off;
         end
      endcase
   end

   assign poff = PLANE_ADDR_BITS'(poff_wide);

   // Rotate right of the CPU byte
   assign rot_dbl  = {req_data.write_data, req_data.write_data} >> rotate_ff[2:0];
   assign rot_byte = rot_dbl[7:0];

   // Write mode 0 source: rotated byte with set/reset per plane
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sr_data[i*8 +: 8] = setreset_ff[4+i] ? {8{setreset_ff[i]}} : rot_byte;
      end
   end

   // Logic op input and bit mask for each write mode
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         lop_src[i*8 +: 8] = (mode_ff[1:0] == WMODE_2) ? {8{req_data.write_data[i]}}
                                                        : sr_data[i*8 +: 8];
      end
   end

   always_comb begin
      case (rotate_ff[4:3])
         LOP_AND: lop_out = lop_src & latch_ff;
         LOP_OR:  lop_out = lop_src | latch_ff;
         LOP_XOR: lop_out = lop_src ^ latch_ff;
         default: lop_out = lop_src;
      endcase
   end

   assign m3_mask = rot_byte & bit_mask_ff;

   always_comb begin
      case (mode_ff[1:0])
         WMODE_0, WMODE_2: begin
            mask_expand = {4{bit_mask_ff}};
            wr_value    = (lop_out & mask_expand) | (latch_ff & ~mask_expand);
         end
         WMODE_1: begin
            mask_expand = '0;
            wr_value    = latch_ff;
         end
         default: begin
            mask_expand = {4{m3_mask}};
            for (int i = 0; i < 4; i++) begin
               wr_value[i*8 +: 8] = ({8{setreset_ff[i]}} & m3_mask)
                                    | (latch_ff[i*8 +: 8] & ~m3_mask);
            end
         end
      endcase
   end

   // Memory write port: clearing pass or CPU write
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = poff;
      mem_wdata = wr_value;
      mem_be    = planes & map_mask_ff;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
         mem_be    = 4'hF;
      end else if (accept && req_data.func && hit) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         for (int i = 0; i < 4; i++) begin
            if (mem_be[i]) begin
               vram_mem[mem_waddr][i*8 +: 8] <= mem_wdata[i*8 +: 8];
            end
         end
      end
      mem_q_ff <= vram_mem[poff];
   end

   // Read path: latch load, color compare or plane select
   assign latch_in = mem_q_ff;

   always_comb begin
      cmp_r = '0;
      for (int i = 0; i < 4; i++) begin
         cmp_r[i*8 +: 8] = (latch_in[i*8 +: 8] & {8{color_ff[4+i]}})
                           ^ {8{color_ff[i] & color_ff[4+i]}};
      end
   end

   always_comb begin
      rd_byte = latch_in[7:0];
      if (mode_ff[2]) begin
         rd_byte = ~(cmp_r[7:0] | cmp_r[15:8] | cmp_r[23:16] | cmp_r[31:24]);
      end else begin
         for (int i = 3; i >= 0; i--) begin
            if (planes_ff[i]) begin
               rd_byte = latch_in[i*8 +: 8];
            end
         end
      end
   end

   // Control, registers and response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         setreset_ff  <= SETRESET_RST;
         color_ff     <= COLOR_RST;
         rotate_ff    <= ROTATE_RST;
         mode_ff      <= MODE_RST;
         bit_mask_ff  <= BIT_MASK_RST;
         map_mask_ff  <= MAP_MASK_RST;
         window_ff    <= WINDOW_RST;
         latch_ff     <= '0;
         res_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // register writes
         if (csr_valid) begin
            case (csr_index)
               CSR_SETRESET: setreset_ff <= csr_data;
               CSR_COLOR:    color_ff    <= csr_data;
               CSR_ROTATE:   rotate_ff   <= csr_data[4:0];
               CSR_MODE:     mode_ff     <= csr_data[6:0];
               CSR_BIT_MASK: bit_mask_ff <= csr_data;
               CSR_MAP_MASK: map_mask_ff <= csr_data[3:0];
               CSR_WINDOW:   window_ff   <= csr_data[4:0];
               default: ;
            endcase
         end

         // result stage to response register
         if (res_valid_ff && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= res_ff;
            res_valid_ff <= 1'b0;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == '1) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  planes_ff <= planes;
                  if (hit && !req_data.func) begin
                     state_ff <= ST_READ;
                  end else begin
                     res_ff.hit       <= hit;
                     res_ff.read_data <= '0;
                     res_valid_ff     <= 1'b1;
                  end
               end
            end
            ST_READ: begin
               latch_ff         <= latch_in;
               res_ff.hit       <= 1'b1;
               res_ff.read_data <= rd_byte;
               res_valid_ff     <= 1'b1;
               state_ff         <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the VGA planar memory access unit: directed and random CPU accesses.
`timescale 1ns / 100ps
module testbench;
   import vpma_pkg::*;

   localparam int PLANE_BITS    = 16;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 8;
   localparam int REPORT_MAX    = 10;
   localparam int RAND_PHASES   = 9;
   localparam int PHASE_WORDS   = 108;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_word_type           req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_word_type           rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   vga_planar_memory_access_unit #(.PLANE_ADDR_BITS(PLANE_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 2 ns clock
   always #1 clock = ~clock;

   // Shadow registers, video memory image and latch
   logic [7:0]  sr_reg, color_reg, mask_reg;
   logic [4:0]  rot_reg, win_reg;
   logic [6:0]  mode_reg;
   logic [3:0]  plane_en_reg;
   logic [31:0] vram_image [0:(1<<PLANE_BITS)-1];
   logic [31:0] latch_image;

   req_word_type access_queue [$];
   rsp_word_type expected_rsp [$];

   bit idle_on = 1'b1;
   int req_gap = 0;
   int stall_left = 0;
   int words_queued = 0;
   int words_checked = 0;
   int fail_count = 0;
   int read_count = 0;
   int write_count = 0;
   int miss_count = 0;
   int setting_count = 0;
   int cycle_count = 0;

   // Expand a 4-bit plane select into byte lanes
   function automatic logic [31:0] fill_planes(input logic [3:0] sel);
      logic [31:0] r;
      for (int i = 0; i < 4; i++) r[8*i +: 8] = {8{sel[i]}};
      return r;
   endfunction

   // Bit mask: 1 takes new data, 0 keeps the latch
   function automatic logic [31:0] merge_latch(input logic [31:0] d, input logic [7:0] m);
      logic [31:0] em;
      em = {4{m}};
      return (d & em) | (latch_image & ~em);
   endfunction

   function automatic logic [31:0] alu_latch(input logic [31:0] d);
      case (rot_reg[4:3])
         LOP_AND: return d & latch_image;
         LOP_OR:  return d | latch_image;
         LOP_XOR: return d ^ latch_image;
         default: return d;
      endcase
   endfunction

   // Data presented to the four planes for a CPU write
   function automatic logic [31:0] write_pattern(input logic [7:0] cpu_byte);
      logic [15:0] doubled;
      logic [7:0]  rotated;
      logic [31:0] d;
      doubled = {cpu_byte, cpu_byte} >> rot_reg[2:0];
      rotated = doubled[7:0];
      case (mode_reg[1:0])
         WMODE_0: begin
            d = {4{rotated}};
            for (int i = 0; i < 4; i++)
               if (sr_reg[4+i]) d[8*i +: 8] = {8{sr_reg[i]}};
            return merge_latch(alu_latch(d), mask_reg);
         end
         WMODE_1: return latch_image;
         WMODE_2: return merge_latch(alu_latch(fill_planes(cpu_byte[3:0])), mask_reg);
         default: return merge_latch(fill_planes(sr_reg[3:0]), rotated & mask_reg);
      endcase
   endfunction

   // Predict one access; updates the memory image and latch
   function automatic rsp_word_type model_access(input req_word_type acc);
      logic [19:0] lo, hi, off, poff;
      logic [3:0]  planes, en, dc;
      logic [1:0]  sel;
      logic [31:0] d, r, w;
      logic [PLANE_BITS-1:0] idx;
      rsp_word_type res;
      res = '0;
      case (win_reg[2:1])
         MAP_A0000_128K: begin lo = WIN_A0000; hi = WIN_C0000; end
         MAP_A0000_64K:  begin lo = WIN_A0000; hi = WIN_B0000; end
         MAP_B0000_32K:  begin lo = WIN_B0000; hi = WIN_B8000; end
         default:        begin lo = WIN_B8000; hi = WIN_C0000; end
      endcase
      if (!win_reg[0] || acc.address < lo || acc.address >= hi) return res;
      off = acc.address - lo;
      case (mode_reg[6:5])
         ADDR_CHAIN4: begin
            planes = 4'b0001 << off[1:0];
            poff = {off[19:2], 2'b00};
         end
         ADDR_ODDEVEN: begin
            // page bit low steers the pair to planes 2/3
            sel = {~win_reg[4], off[0]};
            poff = off;
            if (win_reg[3]) poff[0] = off[16];
            planes = ODDEVEN_PAIR << sel;
         end
         default: begin
            poff = off;
            planes = acc.func ? 4'hF : 4'b0001 << mode_reg[4:3];
         end
      endcase
      idx = poff[PLANE_BITS-1:0];
      res.hit = 1'b1;
      if (acc.func) begin
         d = write_pattern(acc.write_data);
         en = planes & plane_en_reg;
         w = vram_image[idx];
         for (int i = 0; i < 4; i++)
            if (en[i]) w[8*i +: 8] = d[8*i +: 8];
         vram_image[idx] = w;
      end else begin
         latch_image = vram_image[idx];
         if (mode_reg[2]) begin
            // colour compare: planes in the don't-care mask match against cc
            dc = color_reg[7:4];
            r = (latch_image & fill_planes(dc)) ^ fill_planes(color_reg[3:0] & dc);
            res.read_data = ~(r[7:0] | r[15:8] | r[23:16] | r[31:24]);
         end else begin
            // lowest selected plane wins
            for (int i = 3; i >= 0; i--)
               if (planes[i]) res.read_data = latch_image[8*i +: 8];
         end
      end
      return res;
   endfunction

   task automatic flag_error(input string what);
      fail_count++;
      if (fail_count <= REPORT_MAX) $display("[%0t] ERROR: %s", $time, what);
   endtask

   // Request driver: feeds queued words, with random idle bursts
   always @(posedge clock) begin : req_driver
      rsp_word_type exp_rsp;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            exp_rsp = model_access(req_data);
            expected_rsp.push_back(exp_rsp);
            if (!exp_rsp.hit) miss_count++;
            else if (req_data.func) write_count++;
            else read_count++;
         end
         // a stalled word holds
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (access_queue.size() > 0 && idle_on && $urandom_range(0, 7) == 0) begin
               req_gap = $urandom_range(0, 17);
               req_valid <= 1'b0;
            end else if (access_queue.size() > 0) begin
               req_valid <= 1'b1;
               req_data <= access_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: random stall bursts, field-by-field compare
   always @(posedge clock) begin : rsp_monitor
      rsp_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               flag_error($sformatf("response with none pending: hit=%0b read_data=%h",
                                    rsp_data.hit, rsp_data.read_data));
            end else begin
               want = expected_rsp.pop_front();
               words_checked++;
               if (rsp_data.hit !== want.hit)
                  flag_error($sformatf("word %0d hit: expected %0b, got %0b",
                                       words_checked, want.hit, rsp_data.hit));
               if (rsp_data.read_data !== want.read_data)
                  flag_error($sformatf("word %0d read_data: expected %h, got %h",
                                       words_checked, want.read_data, rsp_data.read_data));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 17);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Register write; shadow updated on the accepting edge
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_SETRESET: sr_reg = value;
         CSR_COLOR:    color_reg = value;
         CSR_ROTATE:   rot_reg = value[4:0];
         CSR_MODE:     mode_reg = value[6:0];
         CSR_BIT_MASK: mask_reg = value;
         CSR_MAP_MASK: plane_en_reg = value[3:0];
         default:      win_reg = value[4:0];
      endcase
   endtask

   task automatic apply_config(input logic [7:0] sr, col, rot, mode, bm, mm, win);
      write_reg(CSR_SETRESET, sr);
      write_reg(CSR_COLOR, col);
      write_reg(CSR_ROTATE, rot);
      write_reg(CSR_MODE, mode);
      write_reg(CSR_BIT_MASK, bm);
      write_reg(CSR_MAP_MASK, mm);
      write_reg(CSR_WINDOW, win);
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   task automatic queue_access(input logic wr, input logic [19:0] addr, input logic [7:0] d);
      req_word_type acc;
      acc.func = wr;
      acc.address = addr;
      acc.write_data = d;
      access_queue.push_back(acc);
      words_queued++;
   endtask

   // Wait for every queued word to come back, then let the pipe settle
   task automatic wait_idle();
      @(posedge clock);
      while (words_checked < words_queued) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random access biased into the current window, often on a few hot offsets
   task automatic queue_random_access();
      logic [19:0] base, span, off;
      case (win_reg[2:1])
         MAP_A0000_128K: begin base = WIN_A0000; span = 20'h20000; end
         MAP_A0000_64K:  begin base = WIN_A0000; span = 20'h10000; end
         MAP_B0000_32K:  begin base = WIN_B0000; span = 20'h08000; end
         default:        begin base = WIN_B8000; span = 20'h08000; end
      endcase
      case ($urandom_range(0, 9))
         0:       off = 20'($urandom_range(0, 20'hFFFFF)) - base;
         1, 2:    off = 20'($urandom_range(0, span - 1));
         default: begin
            off = 20'($urandom_range(0, 63));
            off[16] = 1'($urandom_range(0, 1));
            off = off & (span - 1);
         end
      endcase
      queue_access(1'($urandom_range(0, 1)), base + off, 8'($urandom_range(0, 255)));
   endtask

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d of %0d words back",
               CYCLE_LIMIT, words_checked, words_queued);
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      for (int i = 0; i < (1<<PLANE_BITS); i++) vram_image[i] = '0;
      latch_image  = '0;
      sr_reg       = SETRESET_RST;
      color_reg    = COLOR_RST;
      rot_reg      = ROTATE_RST;
      mode_reg     = MODE_RST;
      mask_reg     = BIT_MASK_RST;
      plane_en_reg = MAP_MASK_RST;
      win_reg      = WINDOW_RST;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: odd/even, full 128K window; edges of the address space
      apply_config(SETRESET_RST, COLOR_RST, {3'b000, ROTATE_RST}, {1'b0, MODE_RST},
                   BIT_MASK_RST, {4'h0, MAP_MASK_RST}, {3'b000, WINDOW_RST});
      queue_access(1'b0, 20'h00000, 8'h00);
      queue_access(1'b0, 20'hFFFFF, 8'hFF);
      queue_access(1'b1, 20'hC0000, 8'hAA);
      queue_access(1'b1, 20'hA0000, 8'hFF);
      queue_access(1'b1, 20'hA0001, 8'h5A);
      queue_access(1'b0, 20'hA0000, 8'h00);
      queue_access(1'b0, 20'hA0001, 8'h00);
      queue_access(1'b0, 20'hBFFFF, 8'h00);
      wait_idle();

      // planar, write mode 0 with partial set/reset, rotate and xor; offset wrap
      apply_config(8'h35, 8'h00, {3'b000, LOP_XOR, 3'd3},
                   {1'b0, ADDR_PLANAR, 2'd2, 1'b0, WMODE_0},
                   8'hF0, 8'h0B, {5'b00000, MAP_A0000_128K, 1'b1});
      queue_access(1'b1, 20'hA0010, 8'h81);
      queue_access(1'b1, 20'hB0010, 8'h3C);
      queue_access(1'b0, 20'hA0010, 8'h00);
      wait_idle();

      // chain-4, write mode 2 with and, colour compare reads, 64K window end
      apply_config(8'h00, {4'hF, 4'h5}, {3'b000, LOP_AND, 3'd7},
                   {1'b0, ADDR_CHAIN4, 2'd0, 1'b1, WMODE_2},
                   8'h3C, 8'h0F, {5'b00000, MAP_A0000_64K, 1'b1});
      queue_access(1'b0, 20'hA0010, 8'h00);
      queue_access(1'b1, 20'hA0011, 8'h0F);
      queue_access(1'b1, 20'hA0013, 8'hFA);
      queue_access(1'b0, 20'hA0013, 8'h00);
      queue_access(1'b0, 20'hB0000, 8'h00);
      wait_idle();

      // odd/even page 1 with A16 into A0, write mode 1 latch copy
      apply_config(8'h00, 8'h00, 8'h00, {1'b0, ADDR_ODDEVEN, 2'd0, 1'b0, WMODE_1},
                   8'hFF, 8'h0F, {3'b000, 1'b1, 1'b1, MAP_A0000_128K, 1'b1});
      queue_access(1'b0, 20'hB0004, 8'h00);
      queue_access(1'b1, 20'hA0005, 8'h00);
      queue_access(1'b0, 20'hA0005, 8'h00);
      queue_access(1'b0, 20'hB0005, 8'h00);
      wait_idle();

      // all ones: addressing code three, write mode 3, B8000 window
      apply_config(8'hFF, 8'hFF, 8'h1F, 8'h7F, 8'hFF, 8'h0F, 8'h1F);
      queue_access(1'b0, 20'hB8000, 8'h00);
      queue_access(1'b1, 20'hB8001, 8'hA5);
      queue_access(1'b0, 20'hB8001, 8'h00);
      queue_access(1'b0, 20'hB7FFF, 8'h00);
      wait_idle();

      // all zero: memory disabled
      apply_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_access(1'b0, 20'hA0000, 8'h00);
      queue_access(1'b1, 20'hA0000, 8'hFF);
      wait_idle();

      // random settings and accesses; last phase runs without idling
      for (int p = 0; p < RAND_PHASES; p++) begin
         if (p == RAND_PHASES - 1) idle_on = 1'b0;
         apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 31)), 8'($urandom_range(0, 127)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 15)),
                      {3'b000, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 9) != 0)});
         for (int k = 0; k < PHASE_WORDS; k++) queue_random_access();
         wait_idle();
      end

      $display("Checked %0d accesses: %0d reads, %0d writes, %0d outside the window,",
               words_checked, read_count, write_count, miss_count);
      $display("across %0d register settings, with random idle and stall bursts on both sides",
               setting_count);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
